// ===== src/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int SLOTS     = 64;
    localparam int TOP_LEVEL = 3;
    localparam int LEVELS    = TOP_LEVEL + 1;
    localparam int IW        = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int PW        = $clog2(SLOTS + 1);
    localparam int LW        = (LEVELS > 2) ? $clog2(LEVELS) : 1;

    typedef logic [IW-1:0] t_idx;
    typedef logic [PW-1:0] t_ptr;
    typedef logic [LW-1:0] t_lvl;

    localparam t_ptr NIL = t_ptr'(SLOTS);

    // Slot states
    localparam logic [2:0] SS_FREE   = 3'd0;
    localparam logic [2:0] SS_READY  = 3'd1;
    localparam logic [2:0] SS_RUN    = 3'd2;
    localparam logic [2:0] SS_SLEEP  = 3'd3;
    localparam logic [2:0] SS_ZOMBIE = 3'd4;

    // Operation codes
    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_DISPATCH = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WAKE     = 3'd3;
    localparam logic [2:0] OP_REAP     = 3'd4;

    // Stop reasons
    localparam logic [1:0] RSN_YIELD = 2'd0;
    localparam logic [1:0] RSN_SLEEP = 2'd1;
    localparam logic [1:0] RSN_EXIT  = 2'd2;
    localparam logic [1:0] RSN_BAD   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_NOFREE = 2'd1,
        RES_NONE   = 2'd2,
        RES_WRONG  = 2'd3
    } t_res;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LATCH,
        CMD_FAIL,
        CMD_CR_RD,
        CMD_CR_WR,
        CMD_APPEND,
        CMD_SPLICE,
        CMD_SW_RD,
        CMD_SW_WR,
        CMD_PICK,
        CMD_PICK_WR,
        CMD_SP_RD,
        CMD_SP_WR,
        CMD_WK_INIT,
        CMD_WK_RD,
        CMD_WK_EV,
        CMD_WK_NIL,
        CMD_RP_RD,
        CMD_RP_WR,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd op;
        t_res code;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] reason;
        logic       free_empty;
        logic       run_busy;
        logic       promo_due;
        logic       any_ready;
        logic       slot_ok;
        logic       cur_nil;
        logic       rd_match;
        logic       idx_last;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== src/mlfq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler datapath
// Slot tables, queue pointers, configuration and result registers.
// ----------------------------------------------------------------------------
module mlfq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mlfq_pkg::t_dp_cmd i_cmd,
    output mlfq_pkg::t_dp_stat o_stat,
    input  logic [2:0]       i_op,
    input  logic [5:0]       i_slot,
    input  logic [31:0]      i_now,
    input  logic [1:0]       i_reason,
    input  logic [31:0]      i_channel,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [5:0]       o_result_slot,
    output logic [1:0]       o_status,
    output logic [6:0]       o_woken_count
);
    import mlfq_pkg::*;

    // Slot tables
    logic [2:0]  m_state  [SLOTS];
    t_lvl        m_level  [SLOTS];
    logic [31:0] m_budget [SLOTS];
    logic [31:0] m_tag    [SLOTS];
    t_ptr        m_link   [SLOTS];

    logic [2:0]  rd_state;
    t_lvl        rd_level;
    logic [31:0] rd_budget;
    logic [31:0] rd_tag;
    t_ptr        rd_link;

    t_ptr        r_head [LEVELS];
    t_ptr        r_tail [LEVELS];
    t_ptr        r_free_top;
    t_ptr        r_sleep_head;
    t_ptr        r_running;
    logic [31:0] r_run_start;
    logic [31:0] r_deadline;
    logic [30:0] r_budget_ticks;
    logic [31:0] r_period;
    t_idx        r_idx;
    t_ptr        r_cur;
    t_ptr        r_prev;
    t_ptr        r_nxt;
    t_lvl        r_lvl;
    logic [31:0] r_elapsed;

    logic [2:0]  r_op;
    logic [5:0]  r_slot;
    logic [31:0] r_now;
    logic [1:0]  r_reason;
    logic [31:0] r_channel;

    logic [5:0]  r_rslot;
    t_res        r_res;
    logic [6:0]  r_woken;
    logic        r_out_valid;
    logic [5:0]  r_out_slot;
    t_res        r_out_res;
    logic [6:0]  r_out_woken;

    t_idx        ra;
    t_idx        wa;
    t_idx        wl;
    t_idx        slot_idx;
    logic        we_state, we_level, we_budget, we_tag, we_link;
    logic [2:0]  wd_state;
    t_lvl        wd_level;
    logic [31:0] wd_budget;
    t_ptr        wd_link;
    t_lvl        pick_l;
    t_ptr        pick_head;
    logic        any_ready;
    logic        idx_last;
    logic [31:0] bt32;
    logic [31:0] sp_left;
    logic        sp_drop;

    assign bt32     = {1'b0, r_budget_ticks};
    assign slot_idx = t_idx'(r_slot);
    assign idx_last = (r_idx == t_idx'(SLOTS - 1));

    // Best non-empty level
    always_comb begin
        pick_l    = '0;
        pick_head = NIL;
        any_ready = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_head[l] != NIL) begin
                pick_l    = t_lvl'(l);
                pick_head = r_head[l];
                any_ready = 1'b1;
            end
        end
    end

    assign sp_left = (r_elapsed >= rd_budget) ? 32'd0 : (rd_budget - r_elapsed);
    assign sp_drop = (sp_left == 32'd0) && (rd_level != t_lvl'(TOP_LEVEL));

    always_comb begin
        unique case (i_cmd.op)
            CMD_CR_RD: ra = t_idx'(r_free_top);
            CMD_PICK:  ra = t_idx'(pick_head);
            CMD_SP_RD: ra = t_idx'(r_running);
            CMD_WK_RD: ra = t_idx'(r_cur);
            CMD_RP_RD: ra = slot_idx;
            CMD_SW_RD: ra = r_idx;
            default:   ra = '0;
        endcase
    end

    always_comb begin
        wa        = t_idx'(r_cur);
        wl        = t_idx'(r_cur);
        we_state  = 1'b0;
        we_level  = 1'b0;
        we_budget = 1'b0;
        we_tag    = 1'b0;
        we_link   = 1'b0;
        wd_state  = SS_FREE;
        wd_level  = '0;
        wd_budget = '0;
        wd_link   = NIL;
        unique case (i_cmd.op)
            CMD_INIT: begin
                wa        = r_idx;
                wl        = r_idx;
                we_state  = 1'b1;
                we_level  = 1'b1;
                we_budget = 1'b1;
                we_tag    = 1'b1;
                we_link   = 1'b1;
                wd_link   = t_ptr'(r_idx) + t_ptr'(1);
            end
            CMD_CR_WR: begin
                we_state  = 1'b1;
                wd_state  = SS_READY;
                we_level  = 1'b1;
                we_budget = 1'b1;
                wd_budget = bt32;
                we_link   = 1'b1;
            end
            CMD_APPEND: begin
                if (r_tail[r_lvl] != NIL) begin
                    we_link = 1'b1;
                    wl      = t_idx'(r_tail[r_lvl]);
                    wd_link = r_cur;
                end
            end
            CMD_SPLICE: begin
                if (r_tail[0] != NIL && r_head[1] != NIL) begin
                    we_link = 1'b1;
                    wl      = t_idx'(r_tail[0]);
                    wd_link = r_head[1];
                end
            end
            CMD_SW_WR: begin
                wa = r_idx;
                if (rd_state == SS_READY ||
                    (rd_state == SS_SLEEP && rd_level != '0)) begin
                    we_level  = 1'b1;
                    wd_level  = (rd_level != '0) ? rd_level - t_lvl'(1) : rd_level;
                    we_budget = 1'b1;
                    wd_budget = bt32;
                end
            end
            CMD_PICK_WR: begin
                we_link  = 1'b1;
                we_state = 1'b1;
                wd_state = SS_RUN;
            end
            CMD_SP_WR: begin
                we_level  = 1'b1;
                wd_level  = sp_drop ? rd_level + t_lvl'(1) : rd_level;
                we_budget = 1'b1;
                wd_budget = sp_drop ? bt32 : sp_left;
                we_state  = 1'b1;
                we_link   = 1'b1;
                case (r_reason)
                    RSN_YIELD: wd_state = SS_READY;
                    RSN_SLEEP: begin
                        wd_state = SS_SLEEP;
                        we_tag   = 1'b1;
                        wd_link  = r_sleep_head;
                    end
                    default:   wd_state = SS_ZOMBIE;
                endcase
            end
            CMD_WK_EV: begin
                if (o_stat.rd_match) begin
                    we_state = 1'b1;
                    wd_state = SS_READY;
                    if (r_prev != NIL) begin
                        we_link = 1'b1;
                        wl      = t_idx'(r_prev);
                        wd_link = rd_link;
                    end
                end
            end
            CMD_WK_NIL: we_link = 1'b1;
            CMD_RP_WR: begin
                if (rd_state == SS_ZOMBIE) begin
                    wa       = slot_idx;
                    wl       = slot_idx;
                    we_state = 1'b1;
                    we_link  = 1'b1;
                    wd_link  = r_free_top;
                end
            end
            default: ;
        endcase
    end

    // Table ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we_state)  m_state[wa]  <= wd_state;
        if (we_level)  m_level[wa]  <= wd_level;
        if (we_budget) m_budget[wa] <= wd_budget;
        if (we_tag)    m_tag[wa]    <= (i_cmd.op == CMD_INIT) ? 32'd0 : r_channel;
        if (we_link)   m_link[wl]   <= wd_link;
        rd_state  <= m_state[ra];
        rd_level  <= m_level[ra];
        rd_budget <= m_budget[ra];
        rd_tag    <= m_tag[ra];
        rd_link   <= m_link[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= NIL;
                r_tail[l] <= NIL;
            end
            r_free_top     <= '0;
            r_sleep_head   <= NIL;
            r_running      <= NIL;
            r_run_start    <= '0;
            r_deadline     <= '0;
            r_budget_ticks <= 31'd300;
            r_period       <= 32'd3000;
            r_idx          <= '0;
            r_cur          <= NIL;
            r_prev         <= NIL;
            r_nxt          <= NIL;
            r_lvl          <= '0;
            r_elapsed      <= '0;
            r_op           <= '0;
            r_slot         <= '0;
            r_now          <= '0;
            r_reason       <= '0;
            r_channel      <= '0;
            r_rslot        <= '0;
            r_res          <= RES_OK;
            r_woken        <= '0;
            r_out_valid    <= 1'b0;
            r_out_slot     <= '0;
            r_out_res      <= RES_OK;
            r_out_woken    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BUDGET) r_budget_ticks <= i_cfg_data[30:0];
                else                         r_period       <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && i_cmd.op != CMD_EMIT) r_out_valid <= 1'b0;
            unique case (i_cmd.op)
                CMD_INIT: r_idx <= idx_last ? '0 : r_idx + t_idx'(1);
                CMD_LATCH: begin
                    r_op      <= i_op;
                    r_slot    <= i_slot;
                    r_now     <= i_now;
                    r_reason  <= i_reason;
                    r_channel <= i_channel;
                    r_rslot   <= '0;
                    r_res     <= RES_OK;
                    r_woken   <= '0;
                end
                CMD_FAIL: r_res <= i_cmd.code;
                CMD_CR_RD: r_cur <= r_free_top;
                CMD_CR_WR: begin
                    r_free_top <= rd_link;
                    r_lvl      <= '0;
                    r_rslot    <= 6'(r_cur);
                end
                CMD_APPEND: begin
                    if (r_tail[r_lvl] == NIL) r_head[r_lvl] <= r_cur;
                    r_tail[r_lvl] <= r_cur;
                    if (r_op == OP_WAKE) r_cur <= r_nxt;
                end
                CMD_SPLICE: begin
                    r_deadline <= r_now + r_period;
                    if (r_head[0] == NIL) r_head[0] <= r_head[1];
                    if (r_tail[1] != NIL) r_tail[0] <= r_tail[1];
                    for (int l = 1; l < LEVELS - 1; l++) begin
                        r_head[l] <= r_head[l+1];
                        r_tail[l] <= r_tail[l+1];
                    end
                    r_head[LEVELS-1] <= NIL;
                    r_tail[LEVELS-1] <= NIL;
                end
                CMD_SW_WR: r_idx <= idx_last ? '0 : r_idx + t_idx'(1);
                CMD_PICK: begin
                    r_cur <= pick_head;
                    r_lvl <= pick_l;
                end
                CMD_PICK_WR: begin
                    r_head[r_lvl] <= rd_link;
                    if (rd_link == NIL) r_tail[r_lvl] <= NIL;
                    r_running   <= r_cur;
                    r_run_start <= r_now;
                    r_rslot     <= 6'(r_cur);
                end
                CMD_SP_RD: begin
                    r_cur     <= r_running;
                    r_elapsed <= r_now - r_run_start;
                end
                CMD_SP_WR: begin
                    r_running <= NIL;
                    r_lvl     <= sp_drop ? rd_level + t_lvl'(1) : rd_level;
                    if (r_reason == RSN_SLEEP) r_sleep_head <= r_cur;
                end
                CMD_WK_INIT: begin
                    r_cur  <= r_sleep_head;
                    r_prev <= NIL;
                end
                CMD_WK_EV: begin
                    if (o_stat.rd_match) begin
                        if (r_prev == NIL) r_sleep_head <= rd_link;
                        r_lvl   <= rd_level;
                        r_nxt   <= rd_link;
                        r_woken <= r_woken + 7'd1;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= rd_link;
                    end
                end
                CMD_RP_WR: begin
                    if (rd_state == SS_ZOMBIE) r_free_top <= t_ptr'(slot_idx);
                    else                       r_res      <= RES_WRONG;
                end
                CMD_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_out_slot  <= r_rslot;
                    r_out_res   <= r_res;
                    r_out_woken <= r_woken;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.reason     = r_reason;
    assign o_stat.free_empty = (r_free_top == NIL);
    assign o_stat.run_busy   = (r_running != NIL);
    assign o_stat.promo_due  = (r_now >= r_deadline);
    assign o_stat.any_ready  = any_ready;
    assign o_stat.slot_ok    = (32'(r_slot) < SLOTS);
    assign o_stat.cur_nil    = (r_cur == NIL);
    assign o_stat.rd_match   = (rd_state == SS_SLEEP) && (rd_tag == r_channel);
    assign o_stat.idx_last   = idx_last;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_result_slot = r_out_slot;
    assign o_status      = r_out_res;
    assign o_woken_count = r_out_woken;

endmodule

// ===== src/mlfq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler controller
// Sequences table reads and writes for each operation.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mlfq_pkg::t_dp_stat i_stat,
    output mlfq_pkg::t_dp_cmd  o_cmd
);
    import mlfq_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECODE, S_CR_WR, S_APPEND, S_SW_RD, S_SW_WR,
        S_PICK, S_PICK_WR, S_SP_WR, S_WK_RD, S_WK_EV, S_WK_NIL, S_RP_WR, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = CMD_NONE;
        o_cmd.code = RES_WRONG;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = CMD_INIT;
                if (i_stat.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = CMD_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_DONE;
                o_cmd.op = CMD_FAIL;
                case (i_stat.op)
                    OP_CREATE: begin
                        if (i_stat.free_empty) o_cmd.code = RES_NOFREE;
                        else begin
                            o_cmd.op = CMD_CR_RD;
                            n_state  = S_CR_WR;
                        end
                    end
                    OP_DISPATCH: begin
                        if (!i_stat.run_busy) begin
                            if (i_stat.promo_due) begin
                                o_cmd.op = CMD_SPLICE;
                                n_state  = S_SW_RD;
                            end else begin
                                o_cmd.op = CMD_NONE;
                                n_state  = S_PICK;
                            end
                        end
                    end
                    OP_STOP: begin
                        if (i_stat.run_busy && i_stat.reason != RSN_BAD) begin
                            o_cmd.op = CMD_SP_RD;
                            n_state  = S_SP_WR;
                        end
                    end
                    OP_WAKE: begin
                        o_cmd.op = CMD_WK_INIT;
                        n_state  = S_WK_RD;
                    end
                    OP_REAP: begin
                        if (i_stat.slot_ok) begin
                            o_cmd.op = CMD_RP_RD;
                            n_state  = S_RP_WR;
                        end
                    end
                    default: ;
                endcase
            end
            S_CR_WR: begin
                o_cmd.op = CMD_CR_WR;
                n_state  = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.op = CMD_APPEND;
                n_state  = (i_stat.op == OP_WAKE) ? S_WK_RD : S_DONE;
            end
            S_SW_RD: begin
                o_cmd.op = CMD_SW_RD;
                n_state  = S_SW_WR;
            end
            S_SW_WR: begin
                o_cmd.op = CMD_SW_WR;
                n_state  = i_stat.idx_last ? S_PICK : S_SW_RD;
            end
            S_PICK: begin
                if (!i_stat.any_ready) begin
                    o_cmd.op   = CMD_FAIL;
                    o_cmd.code = RES_NONE;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.op = CMD_PICK;
                    n_state  = S_PICK_WR;
                end
            end
            S_PICK_WR: begin
                o_cmd.op = CMD_PICK_WR;
                n_state  = S_DONE;
            end
            S_SP_WR: begin
                o_cmd.op = CMD_SP_WR;
                n_state  = (i_stat.reason == RSN_YIELD) ? S_APPEND : S_DONE;
            end
            S_WK_RD: begin
                if (i_stat.cur_nil) n_state = S_DONE;
                else begin
                    o_cmd.op = CMD_WK_RD;
                    n_state  = S_WK_EV;
                end
            end
            S_WK_EV: begin
                o_cmd.op = CMD_WK_EV;
                n_state  = i_stat.rd_match ? S_WK_NIL : S_WK_RD;
            end
            S_WK_NIL: begin
                o_cmd.op = CMD_WK_NIL;
                n_state  = S_APPEND;
            end
            S_RP_WR: begin
                o_cmd.op = CMD_RP_WR;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;

endmodule

// ===== src/mlfq_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ task scheduler top level
// Multilevel feedback queue scheduler over a fixed pool of task slots.
// ----------------------------------------------------------------------------
// Dispatch runs a promotion sweep over every slot, through the table port,
//   when the promotion period has run out; wake walks the whole sleep list.
// Flow: one transaction at a time; input stall drops in the same cycle that
//   the result goes valid, so the next is taken even while that result waits.
// Reset: synchronous; a clearing pass over every slot rebuilds the slot
//   tables and the free chain while input stall stays high.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_now,
    input  logic [1:0]  i_reason,
    input  logic [31:0] i_channel,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_result_slot,
    output logic [1:0]  o_status,
    output logic [6:0]  o_woken_count,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import mlfq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each transaction as a chain of table accesses
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Hold slot tables, queue heads and tails, and the result register
    mlfq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_op          (i_op),
        .i_slot        (i_slot),
        .i_now         (i_now),
        .i_reason      (i_reason),
        .i_channel     (i_channel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_slot (o_result_slot),
        .o_status      (o_status),
        .o_woken_count (o_woken_count)
    );

endmodule

// ===== verif/mlfq_task_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ task scheduler testbench
// Drives random and directed scheduler transactions, mirrors the slot tables,
// the level queues, the free stack and the sleep list in a local predictor,
// and checks every result in order against its prediction.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler_top_tb;
    import mlfq_pkg::*;

    localparam int NULLP = SLOTS;
    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_op = '0;
    logic [5:0]  i_slot = '0;
    logic [31:0] i_now = '0;
    logic [1:0]  i_reason = '0;
    logic [31:0] i_channel = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [5:0]  o_result_slot;
    logic [1:0]  o_status;
    logic [6:0]  o_woken_count;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;

    mlfq_task_scheduler_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result record held until the block hands it back
    typedef struct packed {
        logic [5:0] rslot;
        logic [1:0] status;
        logic [6:0] woken;
    } sched_result_t;

    sched_result_t pending_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;

    // Predictor state
    logic [31:0] pr_budget_ticks;
    logic [31:0] pr_promote_period;
    logic [2:0]  pr_state [SLOTS];
    int          pr_level [SLOTS];
    logic [31:0] pr_budget [SLOTS];
    logic [31:0] pr_tag [SLOTS];
    int          pr_next [SLOTS];
    int          pr_head [LEVELS];
    int          pr_tail [LEVELS];
    int          pr_free_top;
    int          pr_sleep_head;
    int          pr_running;
    logic [31:0] pr_run_start;
    logic [31:0] pr_deadline;
    logic [31:0] tick_now = 0;
    logic [31:0] used_tags [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};

    function automatic void sched_reset();
        pr_budget_ticks = 300;
        pr_promote_period = 3000;
        for (int i = 0; i < SLOTS; i++) begin
            pr_state[i] = SS_FREE;
            pr_level[i] = 0;
            pr_budget[i] = 0;
            pr_tag[i] = 0;
            pr_next[i] = i + 1;
        end
        for (int l = 0; l < LEVELS; l++) begin
            pr_head[l] = NULLP;
            pr_tail[l] = NULLP;
        end
        pr_free_top = 0;
        pr_sleep_head = NULLP;
        pr_running = NULLP;
        pr_run_start = 0;
        pr_deadline = 0;
    endfunction

    function automatic void ready_append(int lvl, int s);
        pr_next[s] = NULLP;
        if (pr_tail[lvl] == NULLP) pr_head[lvl] = s;
        else pr_next[pr_tail[lvl]] = s;
        pr_tail[lvl] = s;
    endfunction

    function automatic int ready_pop(int lvl);
        int h;
        h = pr_head[lvl];
        if (h == NULLP) return NULLP;
        pr_head[lvl] = pr_next[h];
        if (pr_head[lvl] == NULLP) pr_tail[lvl] = NULLP;
        pr_next[h] = NULLP;
        return h;
    endfunction

    function automatic void promote_levels();
        int s;
        for (int lvl = 1; lvl < LEVELS; lvl++) begin
            for (int n = 0; n < SLOTS; n++) begin
                s = ready_pop(lvl);
                if (s == NULLP) break;
                pr_level[s] = lvl - 1;
                pr_budget[s] = pr_budget_ticks;
                ready_append(lvl - 1, s);
            end
        end
        s = pr_head[0];
        for (int n = 0; n < SLOTS && s != NULLP; n++) begin
            pr_budget[s] = pr_budget_ticks;
            s = pr_next[s];
        end
        for (int i = 0; i < SLOTS; i++)
            if ((pr_state[i] == SS_RUN || pr_state[i] == SS_SLEEP) && pr_level[i] > 0) begin
                pr_level[i]--;
                pr_budget[i] = pr_budget_ticks;
            end
    endfunction

    function automatic sched_result_t sched_predict(logic [2:0] op, logic [5:0] slot,
                                                    logic [31:0] now, logic [1:0] reason,
                                                    logic [31:0] channel);
        sched_result_t r;
        int s, prev, nxt;
        logic [31:0] elapsed;
        r = '0;
        case (op)
            OP_CREATE: begin
                s = pr_free_top;
                if (s == NULLP) r.status = RES_NOFREE;
                else begin
                    pr_free_top = pr_next[s];
                    pr_state[s] = SS_READY;
                    pr_level[s] = 0;
                    pr_budget[s] = pr_budget_ticks;
                    ready_append(0, s);
                    r.rslot = 6'(s);
                end
            end
            OP_DISPATCH: begin
                if (pr_running != NULLP) r.status = RES_WRONG;
                else begin
                    if (now >= pr_deadline) begin
                        pr_deadline = now + pr_promote_period;
                        promote_levels();
                    end
                    s = NULLP;
                    for (int l = 0; l < LEVELS && s == NULLP; l++) s = ready_pop(l);
                    if (s == NULLP) r.status = RES_NONE;
                    else begin
                        pr_state[s] = SS_RUN;
                        pr_running = s;
                        pr_run_start = now;
                        r.rslot = 6'(s);
                    end
                end
            end
            OP_STOP: begin
                if (pr_running == NULLP || reason == RSN_BAD) r.status = RES_WRONG;
                else begin
                    s = pr_running;
                    elapsed = now - pr_run_start;
                    pr_budget[s] = (elapsed >= pr_budget[s]) ? 32'd0 : pr_budget[s] - elapsed;
                    if (pr_budget[s] == 0 && pr_level[s] < TOP_LEVEL) begin
                        pr_level[s]++;
                        pr_budget[s] = pr_budget_ticks;
                    end
                    pr_running = NULLP;
                    if (reason == RSN_YIELD) begin
                        pr_state[s] = SS_READY;
                        ready_append(pr_level[s], s);
                    end else if (reason == RSN_SLEEP) begin
                        pr_state[s] = SS_SLEEP;
                        pr_tag[s] = channel;
                        pr_next[s] = pr_sleep_head;
                        pr_sleep_head = s;
                    end else begin
                        pr_state[s] = SS_ZOMBIE;
                        pr_next[s] = NULLP;
                    end
                end
            end
            OP_WAKE: begin
                prev = NULLP;
                s = pr_sleep_head;
                for (int n = 0; n < SLOTS && s != NULLP; n++) begin
                    nxt = pr_next[s];
                    if (pr_state[s] == SS_SLEEP && pr_tag[s] == channel) begin
                        if (prev == NULLP) pr_sleep_head = nxt;
                        else pr_next[prev] = nxt;
                        pr_state[s] = SS_READY;
                        ready_append(pr_level[s], s);
                        r.woken++;
                    end else prev = s;
                    s = nxt;
                end
            end
            OP_REAP: begin
                if (pr_state[slot] != SS_ZOMBIE) r.status = RES_WRONG;
                else begin
                    pr_state[slot] = SS_FREE;
                    pr_next[slot] = pr_free_top;
                    pr_free_top = slot;
                end
            end
            default: r.status = RES_WRONG;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mlfq_task_scheduler_top verification failed");
            $finish;
        end
    end

    // Receiver: random stall, compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        sched_result_t exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: slot %0d status %0d woken %0d",
                       o_result_slot, o_status, o_woken_count);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_slot !== exp_r.rslot) begin
                    $error("result_slot: expected %0d actual %0d", exp_r.rslot, o_result_slot);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, o_status);
                    error_count++;
                end
                if (o_woken_count !== exp_r.woken) begin
                    $error("woken_count: expected %0d actual %0d", exp_r.woken, o_woken_count);
                    error_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Send one transaction; predict it at the edge where it is accepted.
    // The block stalls after each accept until its result is emitted, so the edge
    // spent with valid low costs no throughput.
    task automatic send_op(logic [2:0] op, logic [5:0] slot, logic [31:0] now,
                           logic [1:0] reason, logic [31:0] channel);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_slot <= slot;
        i_now <= now;
        i_reason <= reason;
        i_channel <= channel;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(sched_predict(op, slot, now, reason, channel));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every result is back, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * SLOTS + 20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BUDGET) pr_budget_ticks = value & 32'h7FFF_FFFF;
        else pr_promote_period = value;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_DISPATCH, 0, 0, RSN_YIELD, 0);           // nothing ready
        send_op(OP_STOP, 0, 5, RSN_YIELD, 0);                // nothing running
        send_op(OP_REAP, 63, 0, RSN_YIELD, 0);               // reap of a free slot
        send_op(3'd5, 6'h3F, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        send_op(3'd7, 0, 0, 0, 0);
        send_op(OP_WAKE, 0, 0, 0, 32'h0);                    // wake with no sleepers
        for (int i = 0; i < 3; i++) send_op(OP_CREATE, 0, 0, 0, 0);
        send_op(OP_DISPATCH, 0, 10, 0, 0);
        send_op(OP_DISPATCH, 0, 11, 0, 0);                   // dispatch while running
        send_op(OP_STOP, 0, 20, RSN_BAD, 0);                 // bad stop reason
        send_op(OP_STOP, 0, 32'hFFFF_FFFF, RSN_YIELD, 0);    // budget used up, drop
        send_op(OP_DISPATCH, 0, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_STOP, 0, 32'h0000_0010, RSN_SLEEP, 32'hFFFF_FFFF); // elapsed wraps
        send_op(OP_DISPATCH, 0, 30, 0, 0);
        send_op(OP_STOP, 0, 31, RSN_SLEEP, 32'hFFFF_FFFF);
        send_op(OP_WAKE, 0, 0, 0, 32'hFFFF_FFFF);            // two sleepers woken
        send_op(OP_DISPATCH, 0, 40, 0, 0);
        send_op(OP_STOP, 0, 45, RSN_EXIT, 0);
        send_op(OP_REAP, 6'h3F, 0, 0, 0);
        send_op(OP_REAP, pr_free_top == NULLP ? 6'd0 : 6'd2, 0, 0, 0);
        drain();
    endtask

    // Well-formed scheduling life cycles with random content and some noise
    task automatic test_random(int count);
        int pick, z;
        logic [2:0] op;
        logic [5:0] slot;
        logic [1:0] reason;
        for (int k = 0; k < count; k++) begin
            tick_now = tick_now + $urandom_range(($urandom_range(9) == 0) ? 5000 : 400);
            if ($urandom_range(49) == 0) tick_now = $urandom;
            pick = $urandom_range(99);
            reason = 2'($urandom_range(2));
            slot = 6'($urandom);
            if (pick < 15) op = OP_CREATE;
            else if (pick < 40) op = OP_DISPATCH;
            else if (pick < 68) op = OP_STOP;
            else if (pick < 82) op = OP_WAKE;
            else if (pick < 95) begin
                op = OP_REAP;
                z = $urandom_range(SLOTS - 1);
                for (int i = 0; i < SLOTS; i++)
                    if (pr_state[(z + i) % SLOTS] == SS_ZOMBIE) begin
                        z = (z + i) % SLOTS;
                        break;
                    end
                if ($urandom_range(3) != 0) slot = 6'(z);
            end else begin
                op = 3'($urandom);
                reason = 2'($urandom);
            end
            send_op(op, slot, tick_now, reason,
                    ($urandom_range(7) == 0) ? $urandom : used_tags[$urandom_range(3)]);
        end
    endtask

    task automatic test_pause_until_empty();
        test_random(20);
        while (pending_results.size() != 0) @(posedge i_clk);
        test_random(20);
    endtask

    task automatic test_config_sweep();
        drain();
        write_cfg(CFG_BUDGET, 32'd1);
        write_cfg(CFG_PERIOD, 32'd1);
        test_random(150);
        drain();
        write_cfg(CFG_BUDGET, 32'h7FFF_FFFF);
        write_cfg(CFG_PERIOD, 32'hFFFF_FFFF);
        test_random(150);
        drain();
        write_cfg(CFG_BUDGET, 32'hFFFF_FFFF);            // top bit is dropped
        write_cfg(CFG_PERIOD, 32'd500);
        test_random(150);
        drain();
        write_cfg(CFG_BUDGET, $urandom_range(2000, 1));
        write_cfg(CFG_PERIOD, $urandom_range(20000, 1));
        test_random(150);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  stall_pct = 0;  test_random(250);
        send_idle_pct = 82; stall_pct = 0;  test_random(250);
        send_idle_pct = 0;  stall_pct = 82; test_random(250);
        send_idle_pct = 33; stall_pct = 33; test_random(250);
        send_idle_pct = 0;  stall_pct = 0;
    endtask

    initial begin
        sched_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_BUDGET, 32'd50);
        write_cfg(CFG_PERIOD, 32'd3000);
        test_directed();
        test_idle_phases();
        test_pause_until_empty();
        test_config_sweep();
        drain();
        if (error_count == 0) $display("mlfq_task_scheduler_top verification clean");
        else $display("mlfq_task_scheduler_top verification failed");
        $finish;
    end

endmodule
